// ----- design/epd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the EH pointer encoding decoder.
// No dependencies; used by every module of the block.
package epd_pkg;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_NO_BASE  = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_INDIRECT = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        CFG_ENCODING  = 3'd0,
        CFG_ADDR_WIDE = 3'd1,
        CFG_TEXT_BASE = 3'd2,
        CFG_DATA_BASE = 3'd3,
        CFG_FUNC_BASE = 3'd4,
        CFG_BASE_MASK = 3'd5
    } t_cfg_index;

    // Format nibble codes
    localparam logic [3:0] FMT_ABS  = 4'h0;
    localparam logic [3:0] FMT_ULEB = 4'h1;
    localparam logic [3:0] FMT_U2   = 4'h2;
    localparam logic [3:0] FMT_U4   = 4'h3;
    localparam logic [3:0] FMT_U8   = 4'h4;
    localparam logic [3:0] FMT_SLEB = 4'h9;
    localparam logic [3:0] FMT_S2   = 4'ha;
    localparam logic [3:0] FMT_S4   = 4'hb;
    localparam logic [3:0] FMT_S8   = 4'hc;

    // Application codes (encoding bits 6..4)
    localparam logic [2:0] APP_ABS     = 3'd0;
    localparam logic [2:0] APP_PCREL   = 3'd1;
    localparam logic [2:0] APP_TEXTREL = 3'd2;
    localparam logic [2:0] APP_DATAREL = 3'd3;
    localparam logic [2:0] APP_FUNCREL = 3'd4;
    localparam logic [2:0] APP_ALIGNED = 3'd5;

    localparam logic [7:0] ENC_OMIT       = 8'hff;
    localparam logic [3:0] MAX_LEB_BYTES  = 4'd10;
    localparam logic [6:0] LEB_LAST_SHIFT = 7'd63;

    typedef struct packed {
        logic [7:0]  encoding;
        logic        addr_wide;
        logic [63:0] text_base;
        logic [63:0] data_base;
        logic [63:0] func_base;
        logic [2:0]  base_mask;
    } t_cfg;

    // Request from the field stage to the base stage
    typedef struct packed {
        logic        done;       // field complete, apply base
        t_status     status;     // final status when not done
        logic        sgn;
        logic [63:0] acc;
        logic [63:0] field_addr;
    } t_req;

endpackage

// ----- design/epd_field.sv -----
`timescale 1ns / 1ps
// Field gathering stage: holds the per-field state and absorbs one byte per step.
// Depends on epd_pkg.
module epd_field (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  logic [7:0]     i_data_byte,
    input  logic [63:0]    i_byte_address,
    input  logic           i_region_last,
    input  epd_pkg::t_cfg  i_cfg,
    output logic           o_emit,
    output epd_pkg::t_req  o_req
);

    logic [63:0] r_acc, n_acc;
    logic [6:0]  r_shift, n_shift;
    logic [3:0]  r_bytes, n_bytes;
    logic [63:0] r_faddr, n_faddr;
    logic        r_started, n_started;

    logic [3:0]  fmt;
    logic [2:0]  app;
    logic [3:0]  len;
    logic        leb;
    logic        sgn;
    logic        bad;
    logic        misaligned;
    logic        wraps;
    logic [7:0]  payload_byte;
    logic [63:0] shifted;
    logic [63:0] acc_or;
    logic [6:0]  shift_nx;
    logic [3:0]  bytes_nx;
    logic [63:0] fill;
    logic [63:0] eff_faddr;
    logic [63:0] fixed_val;

    always_comb begin
        fmt = i_cfg.encoding[3:0];
        app = i_cfg.encoding[6:4];
        len = 4'd0;
        leb = 1'b0;
        sgn = 1'b0;
        case (fmt)
            epd_pkg::FMT_ABS:  len = i_cfg.addr_wide ? 4'd8 : 4'd4;
            epd_pkg::FMT_ULEB: leb = 1'b1;
            epd_pkg::FMT_U2:   len = 4'd2;
            epd_pkg::FMT_U4:   len = 4'd4;
            epd_pkg::FMT_U8:   len = 4'd8;
            epd_pkg::FMT_SLEB: begin
                leb = 1'b1;
                sgn = 1'b1;
            end
            epd_pkg::FMT_S2: begin
                len = 4'd2;
                sgn = 1'b1;
            end
            epd_pkg::FMT_S4: begin
                len = 4'd4;
                sgn = 1'b1;
            end
            epd_pkg::FMT_S8: begin
                len = 4'd8;
                sgn = 1'b1;
            end
            default: len = 4'd0;
        endcase
        bad = (i_cfg.encoding == epd_pkg::ENC_OMIT) || (!leb && (len == 4'd0));

        misaligned = i_cfg.addr_wide ? (|i_byte_address[2:0]) : (|i_byte_address[1:0]);
        wraps      = i_cfg.addr_wide ? (&i_byte_address[63:3]) : (&i_byte_address[63:2]);

        payload_byte = leb ? {1'b0, i_data_byte[6:0]} : i_data_byte;
        shifted  = r_shift[6] ? 64'd0 : ({56'd0, payload_byte} << r_shift[5:0]);
        acc_or   = r_acc | shifted;
        shift_nx = r_shift + (leb ? 7'd7 : 7'd8);
        bytes_nx = r_bytes + 4'd1;
        fill     = shift_nx[6] ? 64'd0 : ({64{1'b1}} << shift_nx[5:0]);
        eff_faddr = r_started ? r_faddr : i_byte_address;

        // Trim short fixed fields to their length and extend the sign
        case (len)
            4'd2:    fixed_val = {{48{sgn & acc_or[15]}}, acc_or[15:0]};
            4'd4:    fixed_val = {{32{sgn & acc_or[31]}}, acc_or[31:0]};
            default: fixed_val = acc_or;
        endcase
    end

    always_comb begin
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_bytes   = r_bytes;
        n_faddr   = r_faddr;
        n_started = r_started;
        o_emit    = 1'b0;
        o_req.done       = 1'b0;
        o_req.status     = epd_pkg::ST_OK;
        o_req.sgn        = sgn;
        o_req.acc        = acc_or;
        o_req.field_addr = eff_faddr;

        if (bad) begin
            o_emit       = 1'b1;
            o_req.status = epd_pkg::ST_BAD;
        end else if (!r_started && (app == epd_pkg::APP_ALIGNED) && misaligned) begin
            // Drop padding bytes ahead of the field
            if (wraps) begin
                o_emit       = 1'b1;
                o_req.status = epd_pkg::ST_OVERFLOW;
            end else if (i_region_last) begin
                o_emit       = 1'b1;
                o_req.status = epd_pkg::ST_TRUNC;
            end
        end else if (leb) begin
            if ((r_shift == epd_pkg::LEB_LAST_SHIFT) && (|i_data_byte[6:1])
                    && !(sgn && (&i_data_byte[6:0]))) begin
                o_emit       = 1'b1;
                o_req.status = epd_pkg::ST_OVERFLOW;
            end else if (!i_data_byte[7]) begin
                o_emit     = 1'b1;
                o_req.done = 1'b1;
                o_req.acc  = acc_or | ((sgn && i_data_byte[6]) ? fill : 64'd0);
            end else if (bytes_nx >= epd_pkg::MAX_LEB_BYTES) begin
                o_emit       = 1'b1;
                o_req.status = epd_pkg::ST_OVERFLOW;
            end else if (i_region_last) begin
                o_emit       = 1'b1;
                o_req.status = epd_pkg::ST_TRUNC;
            end else begin
                n_acc     = acc_or;
                n_shift   = shift_nx;
                n_bytes   = bytes_nx;
                n_faddr   = eff_faddr;
                n_started = 1'b1;
            end
        end else begin
            if (bytes_nx >= len) begin
                o_emit     = 1'b1;
                o_req.done = 1'b1;
                o_req.acc  = fixed_val;
            end else if (i_region_last) begin
                o_emit       = 1'b1;
                o_req.status = epd_pkg::ST_TRUNC;
            end else begin
                n_acc     = acc_or;
                n_shift   = shift_nx;
                n_bytes   = bytes_nx;
                n_faddr   = eff_faddr;
                n_started = 1'b1;
            end
        end

        // Any result ends the field
        if (o_emit) begin
            n_acc     = 64'd0;
            n_shift   = 7'd0;
            n_bytes   = 4'd0;
            n_faddr   = 64'd0;
            n_started = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 64'd0;
            r_shift   <= 7'd0;
            r_bytes   <= 4'd0;
            r_faddr   <= 64'd0;
            r_started <= 1'b0;
        end else if (i_step) begin
            r_acc     <= n_acc;
            r_shift   <= n_shift;
            r_bytes   <= n_bytes;
            r_faddr   <= n_faddr;
            r_started <= n_started;
        end
    end

endmodule

// ----- design/epd_base.sv -----
`timescale 1ns / 1ps
// Base application stage: adds the selected base to a completed field.
// Depends on epd_pkg.
module epd_base (
    input  epd_pkg::t_req    i_req,
    input  epd_pkg::t_cfg    i_cfg,
    output logic [63:0]      o_value,
    output epd_pkg::t_status o_status
);

    logic [2:0]  app;
    logic [63:0] base;
    logic        no_base;
    logic        bad_app;
    logic [64:0] sum;
    logic        negative;
    logic        range_err;

    always_comb begin
        app     = i_cfg.encoding[6:4];
        base    = 64'd0;
        no_base = 1'b0;
        bad_app = 1'b0;
        case (app)
            epd_pkg::APP_ABS:     base = 64'd0;
            epd_pkg::APP_ALIGNED: base = 64'd0;
            epd_pkg::APP_PCREL:   base = i_req.field_addr;
            epd_pkg::APP_TEXTREL: begin
                base    = i_cfg.text_base;
                no_base = !i_cfg.base_mask[0];
            end
            epd_pkg::APP_DATAREL: begin
                base    = i_cfg.data_base;
                no_base = !i_cfg.base_mask[1];
            end
            epd_pkg::APP_FUNCREL: begin
                base    = i_cfg.func_base;
                no_base = !i_cfg.base_mask[2];
            end
            default: bad_app = 1'b1;
        endcase

        // A negative value subtracts its magnitude: underflow shows as no carry
        sum       = {1'b0, base} + {1'b0, i_req.acc};
        negative  = i_req.sgn & i_req.acc[63];
        range_err = negative ? !sum[64] : sum[64];

        if (!i_req.done) begin
            o_status = i_req.status;
        end else if (bad_app) begin
            o_status = epd_pkg::ST_BAD;
        end else if (no_base) begin
            o_status = epd_pkg::ST_NO_BASE;
        end else if (range_err) begin
            o_status = epd_pkg::ST_OVERFLOW;
        end else if (i_cfg.encoding[7]) begin
            o_status = epd_pkg::ST_INDIRECT;
        end else begin
            o_status = epd_pkg::ST_OK;
        end

        o_value = (o_status == epd_pkg::ST_OK) ? sum[63:0] : 64'd0;
    end

endmodule

// ----- design/eh_pointer_encoding_decoder.sv -----
`timescale 1ns / 1ps
// Top level of the EH pointer encoding decoder.
// Depends on epd_pkg, epd_field and epd_base.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) moves one request per byte: the
//   stream byte, its address and a region-last flag. The block gathers the
//   bytes of one encoded pointer field under the encoding register, applies
//   the selected base and sends one result request (value, status) on the
//   output channel (o_out_valid / i_out_ready) when the field completes,
//   fails, or the region ends early. Bytes that neither complete nor end a
//   field produce no result.
//   Configuration port (i_cfg_valid / o_cfg_ready) is always ready; write
//   registers only while the block is idle.
//   Pipeline: input register -> field stage -> base-add stage -> output
//   register. Throughput is one byte per cycle while o_in_ready is high,
//   set by the field update (one byte shift-merge) that feeds back into
//   the field state registers.
//   Reset clears the field state, empties every stage and loads the
//   register reset values (encoding 0, 8-byte addresses, no base valid).
//   When the receiver stalls, the output register holds its result and each
//   stage behind it fills and holds; o_in_ready drops once all are full.
module eh_pointer_encoding_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [63:0] i_byte_address,
    input  logic        i_region_last,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_value,
    output logic [2:0]  o_status,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    epd_pkg::t_cfg r_cfg;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [63:0] r_in_addr;
    logic        r_in_last;

    // field stage -> base stage
    logic          r_mid_valid;
    epd_pkg::t_req r_mid;
    logic          field_emit;
    epd_pkg::t_req field_req;

    // output register
    logic             r_out_valid;
    logic [63:0]      r_out_value;
    epd_pkg::t_status r_out_status;
    logic [63:0]      base_value;
    epd_pkg::t_status base_status;

    logic out_free;
    logic mid_adv;
    logic mid_free;
    logic in_adv;

    // Stage advance: each stage moves when the one ahead is empty or draining
    assign out_free = !r_out_valid || i_out_ready;
    assign mid_adv  = r_mid_valid && out_free;
    assign mid_free = !r_mid_valid || mid_adv;
    assign in_adv   = r_in_valid && mid_free;

    assign o_in_ready  = !r_in_valid || mid_free;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.encoding  <= 8'd0;
            r_cfg.addr_wide <= 1'b1;
            r_cfg.text_base <= 64'd0;
            r_cfg.data_base <= 64'd0;
            r_cfg.func_base <= 64'd0;
            r_cfg.base_mask <= 3'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                epd_pkg::CFG_ENCODING:  r_cfg.encoding  <= i_cfg_data[7:0];
                epd_pkg::CFG_ADDR_WIDE: r_cfg.addr_wide <= i_cfg_data[0];
                epd_pkg::CFG_TEXT_BASE: r_cfg.text_base <= i_cfg_data;
                epd_pkg::CFG_DATA_BASE: r_cfg.data_base <= i_cfg_data;
                epd_pkg::CFG_FUNC_BASE: r_cfg.func_base <= i_cfg_data;
                epd_pkg::CFG_BASE_MASK: r_cfg.base_mask <= i_cfg_data[2:0];
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // input register: hold while the field stage is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_addr <= i_byte_address;
            r_in_last <= i_region_last;
        end
    end

    epd_field u_field (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (in_adv),
        .i_data_byte    (r_in_byte),
        .i_byte_address (r_in_addr),
        .i_region_last  (r_in_last),
        .i_cfg          (r_cfg),
        .o_emit         (field_emit),
        .o_req          (field_req)
    );

    // field-to-base register: load only bytes that produce a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (in_adv) begin
            r_mid_valid <= field_emit;
        end else if (mid_adv) begin
            r_mid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && field_emit) begin
            r_mid <= field_req;
        end
    end

    epd_base u_base (
        .i_req    (r_mid),
        .i_cfg    (r_cfg),
        .o_value  (base_value),
        .o_status (base_status)
    );

    // output register: hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mid_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_adv) begin
            r_out_value  <= base_value;
            r_out_status <= base_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

endmodule

// ----- tb/sv/epd_tb_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the EH pointer encoding decoder testbench: a bit-exact
// byte-stream decoder and the queue of pointer results it expects.
// Depends on epd_pkg.
package epd_tb_pkg;

    typedef struct packed {
        logic [63:0]      value;
        epd_pkg::t_status status;
    } t_pointer;

    class pointer_scoreboard;
        // register shadow
        logic [7:0]  encoding;
        logic        addr_wide;
        logic [63:0] text_base;
        logic [63:0] data_base;
        logic [63:0] func_base;
        logic [2:0]  base_mask;
        // field in progress
        logic [63:0] acc;
        logic [6:0]  shift;
        logic [3:0]  taken;
        logic [63:0] field_addr;
        logic        started;

        t_pointer    expected_q[$];
        int          errors;

        function new();
            encoding  = 8'h00;
            addr_wide = 1'b1;
            text_base = '0;
            data_base = '0;
            func_base = '0;
            base_mask = '0;
            errors    = 0;
            clear_field();
        endfunction

        function void clear_field();
            acc        = '0;
            shift      = '0;
            taken      = '0;
            field_addr = '0;
            started    = 1'b0;
        endfunction

        // Queue one pointer result and drop the field state.
        function void post(logic [63:0] value, epd_pkg::t_status status);
            t_pointer p;
            p.value  = (status == epd_pkg::ST_OK) ? value : 64'd0;
            p.status = status;
            expected_q.insert(expected_q.size(), p);
            clear_field();
        endfunction

        function void write_reg(epd_pkg::t_cfg_index idx, logic [63:0] data);
            case (idx)
                epd_pkg::CFG_ENCODING:  encoding  = data[7:0];
                epd_pkg::CFG_ADDR_WIDE: addr_wide = data[0];
                epd_pkg::CFG_TEXT_BASE: text_base = data;
                epd_pkg::CFG_DATA_BASE: data_base = data;
                epd_pkg::CFG_FUNC_BASE: func_base = data;
                epd_pkg::CFG_BASE_MASK: base_mask = data[2:0];
                default: ;
            endcase
        endfunction

        // Add the selected base to the gathered field and queue the outcome.
        function void apply_base(logic sgn);
            logic [63:0] base;
            logic [63:0] mag;
            logic [63:0] sum;
            logic        ovf;
            base = 64'd0;
            case (encoding[6:4])
                epd_pkg::APP_ABS, epd_pkg::APP_ALIGNED: base = 64'd0;
                epd_pkg::APP_PCREL: base = field_addr;
                epd_pkg::APP_TEXTREL: begin
                    if (!base_mask[0]) begin
                        post(64'd0, epd_pkg::ST_NO_BASE);
                        return;
                    end
                    base = text_base;
                end
                epd_pkg::APP_DATAREL: begin
                    if (!base_mask[1]) begin
                        post(64'd0, epd_pkg::ST_NO_BASE);
                        return;
                    end
                    base = data_base;
                end
                epd_pkg::APP_FUNCREL: begin
                    if (!base_mask[2]) begin
                        post(64'd0, epd_pkg::ST_NO_BASE);
                        return;
                    end
                    base = func_base;
                end
                default: begin
                    post(64'd0, epd_pkg::ST_BAD);
                    return;
                end
            endcase
            if (sgn && acc[63]) begin
                mag = -acc;
                ovf = (mag > base);
                sum = base - mag;
            end else begin
                ovf = (acc > ~64'd0 - base);
                sum = base + acc;
            end
            if (ovf)
                post(64'd0, epd_pkg::ST_OVERFLOW);
            else if (encoding[7])
                post(64'd0, epd_pkg::ST_INDIRECT);
            else
                post(sum, epd_pkg::ST_OK);
        endfunction

        // Advance the decoder by one accepted byte request.
        function void note_byte(logic [7:0] b, logic [63:0] addr, logic last);
            logic [3:0]  fmt;
            int          len;
            logic        sgn;
            logic        leb;
            logic [63:0] align;
            fmt = encoding[3:0];
            len = 0;
            sgn = 1'b0;
            leb = 1'b0;
            case (fmt)
                epd_pkg::FMT_ABS:  len = addr_wide ? 8 : 4;
                epd_pkg::FMT_ULEB: leb = 1'b1;
                epd_pkg::FMT_U2:   len = 2;
                epd_pkg::FMT_U4:   len = 4;
                epd_pkg::FMT_U8:   len = 8;
                epd_pkg::FMT_SLEB: begin
                    leb = 1'b1;
                    sgn = 1'b1;
                end
                epd_pkg::FMT_S2: begin
                    len = 2;
                    sgn = 1'b1;
                end
                epd_pkg::FMT_S4: begin
                    len = 4;
                    sgn = 1'b1;
                end
                epd_pkg::FMT_S8: begin
                    len = 8;
                    sgn = 1'b1;
                end
                default: ;
            endcase
            if (encoding == epd_pkg::ENC_OMIT || (!leb && len == 0)) begin
                post(64'd0, epd_pkg::ST_BAD);
                return;
            end

            // drop bytes ahead of the first aligned field byte
            if (!started && encoding[6:4] == epd_pkg::APP_ALIGNED) begin
                align = addr_wide ? 64'd8 : 64'd4;
                if ((addr & (align - 64'd1)) != 64'd0) begin
                    if (addr > ~64'd0 - (align - 64'd1))
                        post(64'd0, epd_pkg::ST_OVERFLOW);
                    else if (last)
                        post(64'd0, epd_pkg::ST_TRUNC);
                    return;
                end
            end
            if (!started) begin
                clear_field();
                started    = 1'b1;
                field_addr = addr;
            end

            if (leb) begin
                if (shift == epd_pkg::LEB_LAST_SHIFT && (b & 8'h7e) != 8'h00 &&
                    !(sgn && b[6:0] == 7'h7f)) begin
                    post(64'd0, epd_pkg::ST_OVERFLOW);
                    return;
                end
                if (shift < 7'd64)
                    acc |= {57'd0, b[6:0]} << shift;
                shift = shift + 7'd7;
                taken = taken + 4'd1;
                if (!b[7]) begin
                    if (sgn && shift < 7'd64 && b[6])
                        acc |= ~64'd0 << shift;
                    apply_base(sgn);
                    return;
                end
                if (taken >= epd_pkg::MAX_LEB_BYTES) begin
                    post(64'd0, epd_pkg::ST_OVERFLOW);
                    return;
                end
            end else begin
                if (shift < 7'd64)
                    acc |= {56'd0, b} << shift;
                shift = shift + 7'd8;
                taken = taken + 4'd1;
                if (int'(taken) >= len) begin
                    // a field entered under a longer encoding keeps its low bytes only
                    if (len < 8) begin
                        acc &= (64'd1 << (8 * len)) - 64'd1;
                        if (sgn && acc[8 * len - 1])
                            acc |= ~64'd0 << (8 * len);
                    end
                    apply_base(sgn);
                    return;
                end
            end
            if (last)
                post(64'd0, epd_pkg::ST_TRUNC);
        endfunction

        function void report(string what, logic [63:0] want, logic [63:0] got);
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
        endfunction

        // Compare one accepted result request with the oldest expectation.
        function void check_pointer(logic [63:0] value, logic [2:0] status);
            t_pointer want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual value %h status %0d",
                         $time, value, status);
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value)
                report("value", want.value, value);
            if (status !== want.status)
                report("status", {61'd0, want.status}, {61'd0, status});
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_eh_pointer_encoding_decoder.sv -----
`timescale 1ns / 1ps
// Testbench top for the EH pointer encoding decoder: clock, reset, request
// drivers, result monitor, directed and random byte streams.
// Depends on epd_pkg, epd_tb_pkg and the eh_pointer_encoding_decoder RTL.
module tb_eh_pointer_encoding_decoder;

    localparam int ITEMS_PER_PHASE = 500;
    localparam int SETTLE_CYCLES   = 8;     // pipeline depth plus margin
    localparam int QUIET_LIMIT     = 1000;

    // codes the package leaves unnamed, used to reach the error paths
    localparam logic [3:0] FMT_UNKNOWN  = 4'hd;
    localparam logic [2:0] APP_RESERVED = 3'd7;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte    = '0;
    logic [63:0] i_byte_address = '0;
    logic        i_region_last  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [63:0] o_value;
    logic [2:0]  o_status;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index    = '0;
    logic [63:0] i_cfg_data     = '0;

    epd_tb_pkg::pointer_scoreboard board = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    // shadow of the programmed registers, used to shape well-formed fields
    logic [7:0]  cur_enc  = '0;
    logic        cur_wide = 1'b1;
    logic [63:0] next_addr = '0;

    eh_pointer_encoding_decoder u_top (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stall at random per cycle, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: check every accepted result request and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                board.check_pointer(o_value, o_status);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
                $display("FAIL eh_pointer_encoding_decoder");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] enc_of(logic ind, logic [2:0] app, logic [3:0] fmt);
        return {ind, app, fmt};
    endfunction

    // Send one byte request: idle first at the sender's rate, then hold valid
    // and payload until accepted. Valid stays high on return; the caller
    // either sends the next byte or lowers it in the same step.
    task automatic send_byte(input logic [7:0] data, input logic [63:0] addr,
                             input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= data;
        i_byte_address <= addr;
        i_region_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.note_byte(data, addr, last);
    endtask

    // Drop valid and wait out every expected result plus the pipeline depth,
    // so that a byte with no result cannot still be in flight.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input epd_pkg::t_cfg_index idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // Program all registers once the block is idle. A field left open keeps
    // its gathered bytes and continues under the new encoding.
    task automatic load_config(input logic [7:0] enc, input logic wide,
                               input logic [63:0] text_b, input logic [63:0] data_b,
                               input logic [63:0] func_b, input logic [2:0] mask);
        settle();
        write_reg(epd_pkg::CFG_ENCODING, {56'd0, enc});
        write_reg(epd_pkg::CFG_ADDR_WIDE, {63'd0, wide});
        write_reg(epd_pkg::CFG_TEXT_BASE, text_b);
        write_reg(epd_pkg::CFG_DATA_BASE, data_b);
        write_reg(epd_pkg::CFG_FUNC_BASE, func_b);
        write_reg(epd_pkg::CFG_BASE_MASK, {61'd0, mask});
        i_cfg_valid <= 1'b0;
        cur_enc  = enc;
        cur_wide = wide;
    endtask

    // Mostly ordinary addresses; a few at the bottom and at the wrap point.
    function automatic logic [63:0] pick_address();
        case ($urandom_range(9))
            0: return ~64'd0 - 64'($urandom_range(15));
            1: return 64'($urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] pick_base();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return ~64'd0;
            2: return 64'($urandom_range(4095));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Mostly supported format and application; now and then any byte at all.
    function automatic logic [7:0] pick_encoding();
        logic [3:0] fmt;
        logic [2:0] app;
        logic       ind;
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        case ($urandom_range(8))
            0: fmt = epd_pkg::FMT_ABS;
            1: fmt = epd_pkg::FMT_ULEB;
            2: fmt = epd_pkg::FMT_U2;
            3: fmt = epd_pkg::FMT_U4;
            4: fmt = epd_pkg::FMT_U8;
            5: fmt = epd_pkg::FMT_SLEB;
            6: fmt = epd_pkg::FMT_S2;
            7: fmt = epd_pkg::FMT_S4;
            default: fmt = epd_pkg::FMT_S8;
        endcase
        app = 3'($urandom_range(5));
        ind = ($urandom_range(9) == 0);
        return enc_of(ind, app, fmt);
    endfunction

    // Send one field shaped for the current encoding: alignment padding,
    // then the body, now and then cut short by region_last. One field in
    // ten is plain noise instead.
    task automatic send_field();
        logic [63:0] addr;
        logic [63:0] align;
        logic [7:0]  data;
        logic        leb;
        logic        known;
        logic        last;
        int          len;
        int          pad;
        int          cut;
        int          fill;
        int          k;
        addr = ($urandom_range(9) < 7) ? next_addr : pick_address();
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++) begin
                send_byte(8'($urandom), addr + 64'(k), ($urandom_range(7) == 0));
                items_sent++;
            end
            next_addr = addr + 64'(len);
            return;
        end

        leb   = (cur_enc[3:0] == epd_pkg::FMT_ULEB || cur_enc[3:0] == epd_pkg::FMT_SLEB);
        known = (cur_enc != epd_pkg::ENC_OMIT);
        case (cur_enc[3:0])
            epd_pkg::FMT_ABS:                  len = cur_wide ? 8 : 4;
            epd_pkg::FMT_U2, epd_pkg::FMT_S2:  len = 2;
            epd_pkg::FMT_U4, epd_pkg::FMT_S4:  len = 4;
            epd_pkg::FMT_U8, epd_pkg::FMT_S8:  len = 8;
            epd_pkg::FMT_ULEB, epd_pkg::FMT_SLEB: begin
                case ($urandom_range(9))
                    0: len = 10;
                    1: len = 11;
                    2: len = 9;
                    default: len = $urandom_range(1, 4);
                endcase
            end
            default: begin
                len   = $urandom_range(1, 4);
                known = 1'b0;
            end
        endcase

        // pad up to the address-size grid; these bytes are dropped
        pad = 0;
        if (known && cur_enc[6:4] == epd_pkg::APP_ALIGNED) begin
            align = cur_wide ? 64'd8 : 64'd4;
            pad   = int'((align - (addr & (align - 64'd1))) & (align - 64'd1));
        end
        for (k = 0; k < pad; k++) begin
            send_byte(8'($urandom), addr + 64'(k), ($urandom_range(9) == 0));
            items_sent++;
        end
        addr = addr + 64'(pad);

        cut  = ($urandom_range(9) == 0) ? $urandom_range(0, len - 1) : -1;
        fill = $urandom_range(4);       // 0: all zero above, 1: all ones, else random
        for (k = 0; k < len; k++) begin
            data = 8'($urandom);
            if (k >= 2 && fill == 0)
                data = 8'h00;
            else if (k >= 2 && fill == 1)
                data = 8'hff;
            if (leb) begin
                // tenth byte sits at shift 63: try the edge values there
                if (k == 9) begin
                    case ($urandom_range(4))
                        0: data = 8'h00;
                        1: data = 8'h01;
                        2: data = 8'h7f;
                        3: data = 8'h7e;
                        default: ;
                    endcase
                end
                data[7] = (k < len - 1);
            end
            last = (k == cut) || (k == len - 1 && $urandom_range(4) == 0);
            send_byte(data, addr + 64'(k), last);
            items_sent++;
        end
        next_addr = addr + 64'(len);
    endtask

    task automatic random_segment();
        int n;
        int f;
        load_config(pick_encoding(), 1'($urandom_range(1)), pick_base(), pick_base(),
                    pick_base(), ($urandom_range(1) == 0) ? 3'd7 : 3'($urandom_range(7)));
        n = $urandom_range(2, 8);
        for (f = 0; f < n; f++)
            send_field();
    endtask

    initial begin
        int phase;
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // omit encoding answers any byte with a bad status
        load_config(epd_pkg::ENC_OMIT, 1'b1, 64'd0, 64'd0, 64'd0, 3'd0);
        send_byte(8'h00, 64'd0, 1'b0);
        // unknown format nibble
        load_config(enc_of(1'b0, epd_pkg::APP_ABS, FMT_UNKNOWN), 1'b1, 64'd0, 64'd0,
                    64'd0, 3'd0);
        send_byte(8'hff, ~64'd0, 1'b1);
        // reserved application: bad once the field completes
        load_config(enc_of(1'b0, APP_RESERVED, epd_pkg::FMT_U2), 1'b1, 64'd0, 64'd0,
                    64'd0, 3'd7);
        send_byte(8'h12, 64'd100, 1'b0);
        send_byte(8'h34, 64'd101, 1'b0);
        // data-relative without a valid data base
        load_config(enc_of(1'b0, epd_pkg::APP_DATAREL, epd_pkg::FMT_S2), 1'b1, 64'd0,
                    64'd5, 64'd0, 3'b101);
        send_byte(8'hff, 64'd200, 1'b0);
        send_byte(8'hff, 64'd201, 1'b0);
        // indirect on a value that would otherwise succeed
        load_config(enc_of(1'b1, epd_pkg::APP_PCREL, epd_pkg::FMT_ULEB), 1'b1, 64'd0,
                    64'd0, 64'd0, 3'd7);
        send_byte(8'h05, 64'h1000, 1'b0);
        // aligned: skip near the top wraps, skip of the region's last byte truncates
        load_config(enc_of(1'b0, epd_pkg::APP_ALIGNED, epd_pkg::FMT_ABS), 1'b1, 64'd0,
                    64'd0, 64'd0, 3'd7);
        send_byte(8'haa, ~64'd0 - 64'd2, 1'b0);
        send_byte(8'hbb, 64'h6, 1'b1);
        // 4-byte absolute against a text base that lands exactly on the top
        load_config(enc_of(1'b0, epd_pkg::APP_TEXTREL, epd_pkg::FMT_ABS), 1'b0,
                    ~64'd0 - 64'hffff_ffff, 64'd0, 64'd0, 3'd7);
        for (k = 0; k < 4; k++)
            send_byte(8'hff, 64'h20 + 64'(k), 1'b0);
        // open a ULEB field, then finish it as a 4-byte function-relative one
        load_config(enc_of(1'b0, epd_pkg::APP_ABS, epd_pkg::FMT_ULEB), 1'b1, 64'd0,
                    64'd0, 64'd0, 3'd7);
        send_byte(8'h81, 64'h40, 1'b0);
        load_config(enc_of(1'b0, epd_pkg::APP_FUNCREL, epd_pkg::FMT_U4), 1'b1, 64'd0,
                    64'd0, 64'h1000, 3'd7);
        for (k = 1; k < 4; k++)
            send_byte(8'($urandom), 64'h40 + 64'(k), 1'b0);
        // ten-byte SLEB of -1 (0x7f at shift 63 passes) underflows a zero base
        load_config(enc_of(1'b0, epd_pkg::APP_ABS, epd_pkg::FMT_SLEB), 1'b1, 64'd0,
                    64'd0, 64'd0, 3'd7);
        for (k = 0; k < 9; k++)
            send_byte(8'hff, 64'h80 + 64'(k), 1'b0);
        send_byte(8'h7f, 64'h89, 1'b0);

        // random streams under four idling patterns
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 54;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 54;
                end
                default: begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            while (items_sent < (phase + 1) * ITEMS_PER_PHASE)
                random_segment();
        end

        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS eh_pointer_encoding_decoder");
        else
            $display("FAIL eh_pointer_encoding_decoder");
        $finish;
    end

endmodule

// ----- sim.f -----
design/epd_pkg.sv
design/epd_field.sv
design/epd_base.sv
design/eh_pointer_encoding_decoder.sv
tb/sv/epd_tb_pkg.sv
tb/sv/tb_eh_pointer_encoding_decoder.sv
